>>> design/led_color_convert_and_scale_unit_macros.svh
// Assertion macros used by the checker of the LED color unit.
`ifndef LED_COLOR_CONVERT_AND_SCALE_UNIT_MACROS_SVH
`define LED_COLOR_CONVERT_AND_SCALE_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LCCS_ASSERT_IMPLY(label, ck, rstn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define LCCS_ASSERT_NEXT(label, ck, rstn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/lccs_pkg.sv
// Types, constants and helper functions of the LED color convert and scale unit.
package lccs_pkg;

	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 48;
	localparam int COLOR_W    = 24;
	localparam int PROD_W     = 16;

	localparam logic [7:0] CHAN_MAX     = 8'd255;
	localparam logic [7:0] BRIGHT_RESET = 8'd255;
	localparam logic [7:0] HUE_SPAN     = 8'd43;
	localparam logic [7:0] REM_SCALE    = 8'd6;

	typedef enum logic {
		MODE_RGB = 1'b0,
		MODE_HSV = 1'b1
	} mode_t;

	typedef enum logic {
		REG_IDX_BRIGHTNESS = 1'b0,
		REG_IDX_GRB_ORDER  = 1'b1
	} reg_idx_t;

	// Six hue sectors of the integer HSV conversion.
	typedef enum logic [2:0] {
		RGN_R_TO_Y = 3'd0,
		RGN_Y_TO_G = 3'd1,
		RGN_G_TO_C = 3'd2,
		RGN_C_TO_B = 3'd3,
		RGN_B_TO_M = 3'd4,
		RGN_M_TO_R = 3'd5
	} hue_region_t;

	// Load enables of the conversion stages.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} stage_en_t;

	function automatic logic [7:0] gamma_sq(input logic [7:0] c);
		logic [8:0]  c1;
		logic [17:0] sq;
		c1 = {1'b0, c} + 9'd1;
		sq = (18'(c1) * 18'(c1)) - 18'd1;
		return sq[15:8];
	endfunction

	// Exact floor(x / 255) for x up to 65279.
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] sum;
		sum = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
		return sum[15:8];
	endfunction

	function automatic hue_region_t hue_region(input logic [7:0] h);
		hue_region_t r;
		if (h >= 8'(5 * 43))
			r = RGN_M_TO_R;
		else if (h >= 8'(4 * 43))
			r = RGN_B_TO_M;
		else if (h >= 8'(3 * 43))
			r = RGN_C_TO_B;
		else if (h >= 8'(2 * 43))
			r = RGN_G_TO_C;
		else if (h >= HUE_SPAN)
			r = RGN_Y_TO_G;
		else
			r = RGN_R_TO_Y;
		return r;
	endfunction

	function automatic logic [7:0] hue_base(input hue_region_t r);
		logic [7:0] b;
		case (r)
			RGN_R_TO_Y: b = 8'd0;
			RGN_Y_TO_G: b = HUE_SPAN;
			RGN_G_TO_C: b = 8'(2 * 43);
			RGN_C_TO_B: b = 8'(3 * 43);
			RGN_B_TO_M: b = 8'(4 * 43);
			default:    b = 8'(5 * 43);
		endcase
		return b;
	endfunction

endpackage

>>> design/lccs_convert.sv
// Three-stage RGB/HSV to packed color conversion pipeline.
module lccs_convert (
	input  logic                          clk,
	input  lccs_pkg::stage_en_t           en,
	input  lccs_pkg::mode_t               mode,
	input  logic [7:0]                    chan_a,
	input  logic [7:0]                    chan_b,
	input  logic [7:0]                    chan_c,
	input  logic                          gamma_enable,
	input  logic                          grb_order,
	output logic [lccs_pkg::COLOR_W-1:0]  color_s3
);
	import lccs_pkg::*;

	// stage 1: channel order, hue sector and remainder
	mode_t       mode_s1;
	logic        gam_s1;
	logic [7:0]  a_s1, b_s1, c_s1;
	hue_region_t rgn_s1;
	logic [7:0]  rem_s1;
	logic [7:0]  inv_s_s1;
	logic        sat_zero_s1;

	hue_region_t rgn_in;
	logic [7:0]  off_in;

	always_comb begin
		rgn_in = hue_region(chan_a);
		off_in = chan_a - hue_base(rgn_in);
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			mode_s1     <= mode;
			gam_s1      <= gamma_enable;
			// swap red and green only for RGB input on GRB strips
			if (mode == MODE_RGB && grb_order) begin
				a_s1 <= chan_b;
				b_s1 <= chan_a;
			end else begin
				a_s1 <= chan_a;
				b_s1 <= chan_b;
			end
			c_s1        <= chan_c;
			rgn_s1      <= rgn_in;
			rem_s1      <= 8'(off_in * REM_SCALE);
			inv_s_s1    <= CHAN_MAX - chan_b;
			sat_zero_s1 <= (chan_b == 8'd0);
		end
	end

	// stage 2: gamma squares and first HSV products
	mode_t                  mode_s2;
	logic [COLOR_W-1:0]     rgb_s2;
	logic [7:0]             v_s2;
	logic [7:0]             p_s2;
	logic [PROD_W-1:0]      sr_s2, st_s2;
	hue_region_t            rgn_s2;
	logic                   sat_zero_s2;

	logic [15:0] vp_prod;

	assign vp_prod = c_s1 * inv_s_s1;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			mode_s2 <= mode_s1;
			if (gam_s1)
				rgb_s2 <= {gamma_sq(a_s1), gamma_sq(b_s1), gamma_sq(c_s1)};
			else
				rgb_s2 <= {a_s1, b_s1, c_s1};
			v_s2        <= c_s1;
			p_s2        <= vp_prod[15:8];
			sr_s2       <= b_s1 * rem_s1;
			st_s2       <= b_s1 * (CHAN_MAX - rem_s1);
			rgn_s2      <= rgn_s1;
			sat_zero_s2 <= sat_zero_s1;
		end
	end

	// stage 3: q and t products, sector select
	logic [15:0] q_prod, t_prod;
	logic [7:0]  q_val, t_val;
	logic [COLOR_W-1:0] hsv_col;

	always_comb begin
		q_prod = v_s2 * (CHAN_MAX - sr_s2[15:8]);
		t_prod = v_s2 * (CHAN_MAX - st_s2[15:8]);
		q_val  = q_prod[15:8];
		t_val  = t_prod[15:8];
		if (sat_zero_s2) begin
			hsv_col = {v_s2, v_s2, v_s2};
		end else begin
			case (rgn_s2)
				RGN_R_TO_Y: hsv_col = {v_s2, t_val, p_s2};
				RGN_Y_TO_G: hsv_col = {q_val, v_s2, p_s2};
				RGN_G_TO_C: hsv_col = {p_s2, v_s2, t_val};
				RGN_C_TO_B: hsv_col = {p_s2, q_val, v_s2};
				RGN_B_TO_M: hsv_col = {t_val, p_s2, v_s2};
				default:    hsv_col = {v_s2, p_s2, q_val};
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3)
			color_s3 <= (mode_s2 == MODE_HSV) ? hsv_col : rgb_s2;
	end

endmodule

>>> design/led_color_convert_and_scale_unit.sv
// Top level of the LED color convert and scale unit.
//
// Input stream: one pixel request per accepted beat on s_axis. tuser carries the
// mode (RGB or HSV), tdata the three channel bytes and the gamma flag.
// Output stream: m_axis tdata holds the packed color and the same color with
// every byte scaled by brightness_level / 255 (truncated).
// Config channel: cfg_index 0 writes brightness_level, 1 writes grb_order;
// cfg_ready is always high. Write registers only while the pipe is empty.
// Structure: an accepted input reaches m_axis_tvalid through the five
// pipeline stages (decode, first multiplies, second multiplies and sector
// select, brightness multiply, divide by 255 into the output register).
// Throughput: one pixel per cycle unless stalled; at most one pixel per stage.
// Reset: arst_n clears all valid bits, brightness to 255 and grb_order to 0.
// Stall: when m_axis_tready is low the pipe keeps filling empty stages and
// drops s_axis_tready only once all five stages hold a pixel; nothing is lost
// or repeated.
module led_color_convert_and_scale_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// [7:0] chan_a, [15:8] chan_b, [23:16] chan_c, [24] gamma_enable, rest zero
	input  logic [lccs_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// [0] mode
	input  logic [0:0]                        s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [23:0] packed_color, [47:24] leveled_color
	output logic [lccs_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  lccs_pkg::reg_idx_t                cfg_index,
	input  logic [7:0]                        cfg_data
);
	import lccs_pkg::*;

	logic [7:0] bright_q;
	logic       grb_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bright_q <= BRIGHT_RESET;
			grb_q    <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_IDX_BRIGHTNESS)
				bright_q <= cfg_data;
			else if (cfg_index == REG_IDX_GRB_ORDER)
				grb_q <= cfg_data[0];
		end
	end

	// valid bits and per-stage ready
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	assign rdy5 = !valid_s5 || m_axis_tready;
	assign rdy4 = !valid_s4 || rdy5;
	assign rdy3 = !valid_s3 || rdy4;
	assign rdy2 = !valid_s2 || rdy3;
	assign rdy1 = !valid_s1 || rdy2;

	assign s_axis_tready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (rdy1)
				valid_s1 <= s_axis_tvalid;
			if (rdy2)
				valid_s2 <= valid_s1;
			if (rdy3)
				valid_s3 <= valid_s2;
			if (rdy4)
				valid_s4 <= valid_s3;
			if (rdy5)
				valid_s5 <= valid_s4;
		end
	end

	stage_en_t          conv_en;
	logic [COLOR_W-1:0] color_s3;

	assign conv_en = '{s1: rdy1, s2: rdy2, s3: rdy3};

	lccs_convert u_convert (
		.clk          (clk),
		.en           (conv_en),
		.mode         (mode_t'(s_axis_tuser[0])),
		.chan_a       (s_axis_tdata[7:0]),
		.chan_b       (s_axis_tdata[15:8]),
		.chan_c       (s_axis_tdata[23:16]),
		.gamma_enable (s_axis_tdata[24]),
		.grb_order    (grb_q),
		.color_s3     (color_s3)
	);

	// stage 4: brightness products
	logic [COLOR_W-1:0] color_s4;
	logic [PROD_W-1:0]  prod_x_s4, prod_y_s4, prod_z_s4;

	always_ff @(posedge clk) begin
		if (rdy4) begin
			color_s4  <= color_s3;
			prod_x_s4 <= color_s3[23:16] * bright_q;
			prod_y_s4 <= color_s3[15:8] * bright_q;
			prod_z_s4 <= color_s3[7:0] * bright_q;
		end
	end

	// stage 5: divide by 255, output register
	logic [COLOR_W-1:0] color_s5;
	logic [COLOR_W-1:0] level_s5;

	always_ff @(posedge clk) begin
		if (rdy5) begin
			color_s5 <= color_s4;
			level_s5 <= {div255(prod_x_s4), div255(prod_y_s4), div255(prod_z_s4)};
		end
	end

	assign m_axis_tvalid = valid_s5;
	assign m_axis_tdata  = {level_s5, color_s5};

endmodule

>>> design/lccs_checker.sv
// Port-level checker for the LED color unit, bound to the top level.
`include "led_color_convert_and_scale_unit_macros.svh"

module lccs_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [lccs_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	input logic                             cfg_valid,
	input logic                             cfg_ready
);

	// a stalled result holds its data
	`LCCS_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output changed while stalled")

	// with the output register empty no stage can block the input
	`LCCS_ASSERT_IMPLY(a_ready_when_drained, clk, arst_n, !m_axis_tvalid, s_axis_tready, "input stalled with empty output")

	// brightness scaling never raises a byte
	`LCCS_ASSERT_IMPLY(a_level_le_color, clk, arst_n, m_axis_tvalid, (m_axis_tdata[47:40] <= m_axis_tdata[23:16]) && (m_axis_tdata[39:32] <= m_axis_tdata[15:8]) && (m_axis_tdata[31:24] <= m_axis_tdata[7:0]), "leveled byte above color byte")

	// configuration writes are never refused
	`LCCS_ASSERT_IMPLY(a_cfg_taken, clk, arst_n, cfg_valid || s_axis_tvalid, cfg_ready, "config write refused")

endmodule

bind led_color_convert_and_scale_unit lccs_checker u_lccs_checker (.*);

>>> verif/tb_led_color_convert_and_scale_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench of the LED color convert and scale unit.
module tb_led_color_convert_and_scale_unit;
	import lccs_pkg::*;

	localparam int HALF_PERIOD   = 2;
	localparam int RESET_CYCLES  = 6;
	localparam int PIPE_LATENCY  = 5;
	localparam int STALL_LIMIT   = 2000;
	localparam int LONG_HOLD     = 60;
	localparam int SEGMENTS      = 6;
	localparam int SEGMENT_ITEMS = 117;

	typedef struct packed {
		logic [COLOR_W-1:0] leveled;
		logic [COLOR_W-1:0] color;
	} led_result_t;

	// Predicts the converted and leveled colors and checks them in order.
	class color_scoreboard;
		logic [7:0]  brightness;
		logic        grb_swap;
		led_result_t pending_colors[$];
		int          errors;
		int          rgb_items;
		int          hsv_items;
		int          gamma_items;
		int          gray_items;
		int          reg_writes;
		int          results_seen;

		function new();
			brightness = BRIGHT_RESET;
			grb_swap   = 1'b0;
		endfunction

		function void write_register(reg_idx_t idx, logic [7:0] d);
			reg_writes++;
			case (idx)
				REG_IDX_BRIGHTNESS: brightness = d;
				REG_IDX_GRB_ORDER:  grb_swap   = d[0];
				default: ;
			endcase
		endfunction

		function logic [7:0] square_law(logic [7:0] v);
			int unsigned w;
			w = v;
			w = w + 1;
			return 8'(((w * w) - 1) >> 8);
		endfunction

		function logic [7:0] level_byte(logic [7:0] v);
			int unsigned w;
			int unsigned k;
			w = v;
			k = brightness;
			return 8'((w * k) / CHAN_MAX);
		endfunction

		function led_result_t convert_pixel(mode_t mode, logic [7:0] a, logic [7:0] b,
				logic [7:0] c, logic gam);
			logic [7:0]  x, y, z;
			int unsigned h, s, v, rem, p, q, t;
			hue_region_t rgn;
			led_result_t r;
			if (mode == MODE_RGB) begin
				x = grb_swap ? b : a;
				y = grb_swap ? a : b;
				z = c;
				if (gam) begin
					x = square_law(x);
					y = square_law(y);
					z = square_law(z);
				end
			end else if (b == 8'd0) begin
				// zero saturation: gray at the value level
				x = c;
				y = c;
				z = c;
			end else begin
				h = a;
				s = b;
				v = c;
				rgn = hue_region_t'(h / HUE_SPAN);
				rem = (h % HUE_SPAN) * REM_SCALE;
				p = (v * (CHAN_MAX - s)) >> 8;
				q = (v * (CHAN_MAX - ((s * rem) >> 8))) >> 8;
				t = (v * (CHAN_MAX - ((s * (CHAN_MAX - rem)) >> 8))) >> 8;
				case (rgn)
					RGN_R_TO_Y: {x, y, z} = {8'(v), 8'(t), 8'(p)};
					RGN_Y_TO_G: {x, y, z} = {8'(q), 8'(v), 8'(p)};
					RGN_G_TO_C: {x, y, z} = {8'(p), 8'(v), 8'(t)};
					RGN_C_TO_B: {x, y, z} = {8'(p), 8'(q), 8'(v)};
					RGN_B_TO_M: {x, y, z} = {8'(t), 8'(p), 8'(v)};
					default:    {x, y, z} = {8'(v), 8'(p), 8'(q)};
				endcase
			end
			r.color   = {x, y, z};
			r.leveled = {level_byte(x), level_byte(y), level_byte(z)};
			return r;
		endfunction

		function void note_input(mode_t mode, logic [IN_DATA_W-1:0] data);
			if (mode == MODE_RGB) begin
				rgb_items++;
				if (data[24])
					gamma_items++;
			end else begin
				hsv_items++;
				if (data[15:8] == 8'd0)
					gray_items++;
			end
			pending_colors.push_back(convert_pixel(mode, data[7:0], data[15:8],
				data[23:16], data[24]));
		endfunction

		function void check_result(logic [OUT_DATA_W-1:0] data);
			led_result_t got;
			led_result_t want;
			got = data;
			results_seen++;
			if (pending_colors.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %012h", $time, data);
				errors++;
				return;
			end
			want = pending_colors.pop_front();
			if (got.color !== want.color) begin
				$display("%0t: packed_color mismatch, expected %06h, got %06h",
					$time, want.color, got.color);
				errors++;
			end
			if (got.leveled !== want.leveled) begin
				$display("%0t: leveled_color mismatch, expected %06h, got %06h",
					$time, want.leveled, got.leveled);
				errors++;
			end
		endfunction

		function int pending();
			return pending_colors.size();
		endfunction

		function int finish_report();
			if (pending_colors.size() != 0) begin
				$display("%0t: %0d expected results never arrived", $time,
					pending_colors.size());
				errors += pending_colors.size();
			end
			return errors;
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic [0:0]            s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_valid;
	logic                  cfg_ready;
	reg_idx_t              cfg_index;
	logic [7:0]            cfg_data;

	color_scoreboard sb;
	int              send_idle_pct;
	int              recv_idle_pct;
	bit              hold_off_req;
	int              hold_left;
	int              quiet_cycles;

	led_color_convert_and_scale_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Receiver: random stalls, or a long counted hold-off when requested.
	always @(negedge clk) begin
		if (hold_off_req) begin
			hold_left = LONG_HOLD;
			hold_off_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result(m_axis_tdata);
			if (s_axis_tvalid && s_axis_tready)
				sb.note_input(mode_t'(s_axis_tuser[0]), s_axis_tdata);
			if (cfg_valid && cfg_ready)
				sb.write_register(cfg_index, cfg_data);
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic send_pixel(input mode_t mode, input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c, input logic gam, input logic [6:0] pad);
		@(negedge clk);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= $urandom;
			s_axis_tuser  <= 1'($urandom);
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= mode;
		s_axis_tdata  <= {pad, gam, c, b, a};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic send_random_pixel();
		logic [7:0] ch[3];
		for (int k = 0; k < 3; k++) begin
			case ($urandom_range(7))
				0: ch[k] = 8'd0;
				1: ch[k] = CHAN_MAX;
				// land on or just below a hue region boundary
				2: ch[k] = 8'(43 * $urandom_range(1, 5) - $urandom_range(1));
				default: ch[k] = 8'($urandom);
			endcase
		end
		send_pixel(mode_t'($urandom_range(1)), ch[0], ch[1], ch[2], 1'($urandom_range(1)),
			($urandom_range(9) == 0) ? 7'($urandom) : 7'd0);
	endtask

	task automatic write_register(input reg_idx_t idx, input logic [7:0] d);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Stop offering and hold until every pending result is out.
	task automatic drain_pipe();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (sb.pending() > 0)
			@(posedge clk);
	endtask

	task automatic configure(input logic [7:0] bright, input logic [7:0] grb);
		drain_pipe();
		write_register(REG_IDX_BRIGHTNESS, bright);
		write_register(REG_IDX_GRB_ORDER, grb);
	endtask

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		m_axis_tready = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = REG_IDX_BRIGHTNESS;
		cfg_data      = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_off_req  = 1'b0;
		hold_left     = 0;
		quiet_cycles  = 0;
		sb = new();
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// directed pixels under the reset settings
		send_pixel(MODE_RGB, 8'h00, 8'h00, 8'h00, 1'b0, 7'd0);
		send_pixel(MODE_RGB, 8'hff, 8'hff, 8'hff, 1'b0, 7'd0);
		send_pixel(MODE_RGB, 8'hff, 8'hff, 8'hff, 1'b1, 7'd0);
		send_pixel(MODE_RGB, 8'h00, 8'h00, 8'h00, 1'b1, 7'd0);
		send_pixel(MODE_RGB, 8'h12, 8'h80, 8'hc3, 1'b1, 7'd0);
		// unused upper tdata bits must be ignored
		send_pixel(MODE_RGB, 8'h55, 8'haa, 8'h01, 1'b0, 7'h7f);
		send_pixel(MODE_HSV, 8'h00, 8'h00, 8'hff, 1'b0, 7'd0);
		send_pixel(MODE_HSV, 8'h80, 8'h00, 8'h40, 1'b1, 7'h2a);
		send_pixel(MODE_HSV, 8'd0, 8'hff, 8'hff, 1'b0, 7'd0);
		send_pixel(MODE_HSV, 8'd42, 8'hff, 8'hff, 1'b0, 7'd0);
		send_pixel(MODE_HSV, 8'd43, 8'hff, 8'hff, 1'b1, 7'd0);
		send_pixel(MODE_HSV, 8'd86, 8'hc0, 8'h80, 1'b0, 7'd0);
		send_pixel(MODE_HSV, 8'd129, 8'h80, 8'hff, 1'b0, 7'd0);
		send_pixel(MODE_HSV, 8'd172, 8'hff, 8'h7f, 1'b0, 7'd0);
		send_pixel(MODE_HSV, 8'd214, 8'hff, 8'hff, 1'b0, 7'd0);
		send_pixel(MODE_HSV, 8'd215, 8'hff, 8'hff, 1'b0, 7'd0);
		send_pixel(MODE_HSV, 8'd255, 8'hff, 8'hff, 1'b1, 7'd0);
		send_pixel(MODE_HSV, 8'd255, 8'h01, 8'h00, 1'b0, 7'd0);
		// swapped order, brightness off; HSV must ignore the swap
		configure(8'd0, 8'hff);
		send_pixel(MODE_RGB, 8'h11, 8'h22, 8'h33, 1'b0, 7'd0);
		send_pixel(MODE_RGB, 8'hff, 8'h00, 8'h80, 1'b1, 7'd0);
		send_pixel(MODE_HSV, 8'd10, 8'hff, 8'hff, 1'b0, 7'd0);
		// only bit 0 of the order write counts
		configure(8'd1, 8'h02);
		send_pixel(MODE_RGB, 8'hff, 8'hff, 8'hff, 1'b0, 7'd0);
		send_pixel(MODE_HSV, 8'd100, 8'd200, 8'd250, 1'b0, 7'd0);
		configure(8'd254, 8'h00);
		send_pixel(MODE_RGB, 8'hfe, 8'h01, 8'h80, 1'b0, 7'd0);

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			case (seg)
				0: configure(CHAN_MAX, 8'h00);
				1: configure(8'd0, 8'h01);
				2: configure(8'($urandom_range(2, 253)), 8'hff);
				3: configure(8'd1, 8'hfe);
				4: configure(8'd128, 8'h01);
				default: configure(8'($urandom), 8'($urandom));
			endcase
			send_idle_pct = (seg < 2) ? 24 : (seg < 4) ? 74 : 0;
			recv_idle_pct = (seg < 2) ? 74 : (seg < 4) ? 24 : 0;
			// fill the pipe against a stalled output
			if (seg == 4)
				hold_off_req = 1'b1;
			for (int i = 0; i < SEGMENT_ITEMS; i++) begin
				if (seg == 2 && i == SEGMENT_ITEMS / 2)
					drain_pipe();
				send_random_pixel();
			end
		end

		drain_pipe();
		repeat (PIPE_LATENCY + 3) @(posedge clk);
		$display("Covered %0d RGB pixels (%0d with gamma) and %0d HSV pixels (%0d gray),",
			sb.rgb_items, sb.gamma_items, sb.hsv_items, sb.gray_items);
		$display("%0d results checked across %0d register writes.", sb.results_seen,
			sb.reg_writes);
		if (sb.finish_report() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
